@@ sv/aes_pkg.sv @@
// Package with AES types, constants and the byte transforms.
package aes_pkg;

  localparam int MaxRounds = 14;
  localparam int KeyWords  = 2 * (MaxRounds + 1);
  localparam int KeyAw     = $clog2(KeyWords);

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ENCRYPT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  key_index;
    logic        key_half;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits [127-8i -: 8].
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = r + 4 * ((c + r) % 4);
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

endpackage

@@ sv/aes_ram.sv @@
// Generic single-port write, single-port read RAM with registered read data.
module aes_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

@@ sv/aes_block_encrypt.sv @@
// AES encryption core: key store, shared round unit and round sequencer.
// An encrypt request passes S_HIGH and S_LOW once for each of its Nr+1 round keys (Nr is
// 10, 12 or 14), since one 64-bit key store read port delivers each round key in two
// halves to the single shared round unit. The next request is taken the cycle after the
// last round if the result register can take the block, else once S_DONE is left; a load
// leaves the core idle. in_ready is low while a block is in flight or a finished block waits
// for the result register to empty.
// Reset (synchronous, rst_n low) clears the sequencer, the output valid and sets
// key_rounds to 10; the round key store holds no defined value until written.
module aes_block_encrypt
  import aes_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  aes_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output aes_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [3:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_HIGH, S_LOW, S_DONE} state_t;

  state_t       state_r;
  logic [3:0]   key_rounds_r;
  logic [3:0]   round_r;     // round key being applied
  logic [3:0]   nr_r;        // round count of this request
  logic [127:0] state_blk_r;
  logic [63:0]  key_hi_r;    // high half of the current round key
  logic         out_valid_r;
  aes_out_t     out_data_r;

  logic [KeyAw-1:0] rd_addr;
  logic [63:0]      rd_data;
  logic             wr_en;
  logic [3:0]       nr_sel;
  logic             in_fire;
  logic             out_load;

  // The result register parts the sequencer from the receiver: a new request may
  // start while the previous result still waits there.
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished block moves into the result register when that register is empty
  // or is being emptied in the same cycle; otherwise it waits in S_DONE.
  assign out_load = ((state_r == S_LOW) && (round_r == nr_r) && (!out_valid_r || out_ready)) ||
                    ((state_r == S_DONE) && out_ready);

  // Load requests with an index past the last round key are dropped.
  assign wr_en = in_fire && (in_data.func == FUNC_LOAD) &&
                 (in_data.key_index <= 4'(MaxRounds));

  always_comb begin
    nr_sel = 4'd10;
    if (key_rounds_r > 4'd10) nr_sel = 4'd12;
    if (key_rounds_r > 4'd12) nr_sel = 4'd14;
    if (nr_sel > 4'(MaxRounds)) nr_sel = 4'(MaxRounds);
  end

  // The read address is issued in the state before the half it feeds: in S_HIGH the
  // low half of the current key is requested, in S_LOW the high half of the next.
  always_comb begin
    unique case (state_r)
      S_HIGH:  rd_addr = KeyAw'({round_r, 1'b1});
      S_LOW:   rd_addr = KeyAw'({round_r + 4'd1, 1'b0});
      default: rd_addr = KeyAw'(0);
    endcase
  end

  aes_ram #(.Width(64), .Depth(KeyWords)) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (KeyAw'({in_data.key_index, in_data.key_half})),
    .wr_data (in_data.data_high),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared round unit: the key addition for round zero alone, full rounds in
  // between, and the last round without the column mix.
  logic [127:0] ss_out, rnd_pre, rnd_out;
  assign ss_out = sub_shift(state_blk_r);
  always_comb begin
    if (round_r == 4'd0) rnd_pre = state_blk_r;
    else if (round_r == nr_r) rnd_pre = ss_out;
    else rnd_pre = mix_columns(ss_out);
    rnd_out = rnd_pre ^ {key_hi_r, rd_data};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      key_rounds_r <= 4'd10;
      out_valid_r  <= 1'b0;
      round_r      <= '0;
    end else begin
      if (cfg_valid) key_rounds_r <= cfg_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (out_load) out_data_r <= aes_out_t'((state_r == S_DONE) ? state_blk_r : rnd_out);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_data.func == FUNC_ENCRYPT) begin
            state_blk_r <= {in_data.data_high, in_data.data_low};
            nr_r        <= nr_sel;
            round_r     <= '0;
            state_r     <= S_HIGH;
          end
        end
        S_HIGH: begin
          // The high half read was issued in the state before this one.
          key_hi_r <= rd_data;
          state_r  <= S_LOW;
        end
        S_LOW: begin
          // The low half arrives now, so the round completes this cycle.
          state_blk_r <= rnd_out;
          if (round_r == nr_r) begin
            state_r <= out_load ? S_IDLE : S_DONE;
          end else begin
            round_r <= round_r + 4'd1;
            state_r <= S_HIGH;
          end
        end
        S_DONE: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The read issued in S_IDLE must address round zero's high half too.
  // (rd_addr defaults to zero there, which is that word.)

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accepted while busy");

  property p_round_bound;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> (round_r <= nr_r);
  endproperty
  a_round_bound: assert property (p_round_bound) else $error("round past count");

  property p_done_result;
    @(posedge clk) disable iff (!rst_n) out_load |=> out_valid_r;
  endproperty
  a_done_result: assert property (p_done_result) else $error("result lost");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while waiting");

endmodule

@@ tb/tb_aes_block_encrypt.sv @@
// Testbench for the AES block encryption core: directed and random requests against a predictor.
module tb_aes_block_encrypt;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Margin for the drain after the last result, and a limit for the watchdog.
  localparam int DrainCycles = 64;
  localparam int WatchLimit  = 20000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  aes_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  aes_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [3:0] cfg_data = '0;

  always #2 clk = ~clk;

  aes_block_encrypt u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: our own copy of the expanded key and the round count.
  logic [63:0] key_words [KeyWords];
  logic [3:0]  round_setting;
  aes_out_t    cipher_queue [$];
  int          error_count;
  int          idle_cycles;
  bit          hold_receiver;
  bit          burst_mode;

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // S-box computed from the field inverse and the affine map.
  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] r, b, p, aa, bb;
    int e;
    r = 8'h01;
    b = x;
    e = 254;
    while (e != 0) begin
      if (e & 1) begin
        p = '0; aa = r; bb = b;
        for (int i = 0; i < 8; i++) begin
          if (bb[0]) p ^= aa;
          aa = gmul2(aa);
          bb = bb >> 1;
        end
        r = p;
      end
      p = '0; aa = b; bb = b;
      for (int i = 0; i < 8; i++) begin
        if (bb[0]) p ^= aa;
        aa = gmul2(aa);
        bb = bb >> 1;
      end
      b = p;
      e = e >> 1;
    end
    return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
      ^ 8'h63;
  endfunction

  function automatic aes_out_t encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3;
    logic [63:0] kh, kl;
    int nr;
    aes_out_t res;
    nr = 10;
    if (round_setting > 10) nr = 12;
    if (round_setting > 12) nr = 14;
    if (nr > MaxRounds) nr = MaxRounds;
    for (int i = 0; i < 8; i++) begin
      st[i]     = hi[63 - 8 * i -: 8];
      st[8 + i] = lo[63 - 8 * i -: 8];
    end
    for (int rnd = 0; rnd <= nr; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[r + 4 * c] = sbox_calc(st[r + 4 * ((c + r) % 4)]);
        st = tmp;
        if (rnd < nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4 * c]; a1 = st[4 * c + 1]; a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
            st[4 * c]     = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
            st[4 * c + 1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
            st[4 * c + 2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
            st[4 * c + 3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
          end
        end
      end
      kh = key_words[2 * rnd];
      kl = key_words[2 * rnd + 1];
      for (int i = 0; i < 8; i++) begin
        st[i]     ^= kh[63 - 8 * i -: 8];
        st[8 + i] ^= kl[63 - 8 * i -: 8];
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.cipher_high[63 - 8 * i -: 8] = st[i];
      res.cipher_low[63 - 8 * i -: 8]  = st[8 + i];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sends one request and updates the predictor when it is accepted.
  task automatic send_request(input aes_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (req.func == FUNC_LOAD) begin
      if (req.key_index <= MaxRounds) begin
        key_words[2 * req.key_index + req.key_half] = req.data_high;
      end
    end else begin
      cipher_queue.push_back(encrypt_block(req.data_high, req.data_low));
    end
    // In burst mode valid stays high into the next request unless a random gap is drawn; otherwise a random gap.
    if (!burst_mode || $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, burst_mode ? 1 : 4)) @(posedge clk);
    end
  endtask

  task automatic load_key(input int idx, input bit half, input logic [63:0] val);
    aes_in_t req;
    req = '0;
    req.func = FUNC_LOAD;
    req.key_index = idx[3:0];
    req.key_half = half;
    req.data_high = val;
    req.data_low = {$urandom, $urandom};
    send_request(req);
  endtask

  task automatic encrypt(input logic [63:0] hi, input logic [63:0] lo);
    aes_in_t req;
    req = '0;
    req.func = FUNC_ENCRYPT;
    req.key_index = 4'($urandom_range(0, 15));
    req.key_half = 1'($urandom_range(0, 1));
    req.data_high = hi;
    req.data_low = lo;
    send_request(req);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register writes happen only with the core idle.
  task automatic write_rounds(input logic [3:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    round_setting = val;
  endtask

  task automatic test_load_all_keys();
    for (int i = 0; i <= MaxRounds; i++) begin
      load_key(i, 1'b0, rand64());
      load_key(i, 1'b1, rand64());
    end
  endtask

  task automatic test_directed();
    // Out of range key indexes must be ignored by the core.
    load_key(15, 1'b0, '1);
    load_key(15, 1'b1, 64'h0123_4567_89ab_cdef);
    encrypt('0, '0);
    encrypt('1, '1);
    encrypt(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    encrypt(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    // Reload one key half and use it right away.
    load_key(0, 1'b1, 64'hdead_beef_cafe_f00d);
    encrypt(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
  endtask

  task automatic test_round_settings();
    logic [3:0] settings [7] = '{4'd0, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};
    foreach (settings[k]) begin
      write_rounds(settings[k]);
      encrypt(rand64(), rand64());
      encrypt(rand64(), rand64());
    end
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        write_rounds(4'($urandom_range(0, 15)));
        burst_mode = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 9) < 2)
        load_key($urandom_range(0, 15), 1'($urandom_range(0, 1)), rand64());
      else
        encrypt(rand64(), rand64());
    end
  endtask

  // Receiver holds off for a long time while the sender keeps offering.
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    burst_mode = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
      for (int n = 0; n < 20; n++) encrypt(rand64(), rand64());
    join
    burst_mode = 1'b0;
    // Sender waits for every result before going on.
    wait_drained();
    for (int n = 0; n < 10; n++) encrypt(rand64(), rand64());
  endtask

  // Receiver stall pattern, forced low during a hold.
  always @(posedge clk) begin
    if (hold_receiver) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($time % 2000 < 500);
  end

  // Result checker.
  always @(posedge clk) begin
    aes_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_queue.size() == 0) begin
        report_mismatch("unexpected result", out_data.cipher_high, '0);
      end else begin
        want = cipher_queue.pop_front();
        if (out_data.cipher_high !== want.cipher_high)
          report_mismatch("cipher_high", out_data.cipher_high, want.cipher_high);
        if (out_data.cipher_low !== want.cipher_low)
          report_mismatch("cipher_low", out_data.cipher_low, want.cipher_low);
      end
    end
  end

  // Watchdog on cycles with no handshake on any interface.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    hold_receiver = 1'b0;
    burst_mode = 1'b0;
    round_setting = 4'd10;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_all_keys();
    test_directed();
    test_round_settings();
    test_backpressure();
    test_random(1100);
    wait_drained();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
